### rtl/crc32hs_pkg.sv
package crc32hs_pkg;

    localparam logic [31:0] CRC_ALL_ONES       = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY_REFLECTED = 32'hEDB8_8320;
    localparam logic [7:0]  HEADER_SKIP_RESET  = 8'd16;

    // one input beat as held in the input register
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_of_file;
        logic       last_of_file;
    } item_t;

    // reflected crc-32, one byte folded in, lsb first
    function automatic logic [31:0] crc_update_byte(input logic [31:0] crc,
                                                    input logic [7:0]  data);
        logic [31:0] c;
        c = crc ^ {24'd0, data};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY_REFLECTED;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

### rtl/crc32hs_in_reg.sv
module crc32hs_in_reg
    import crc32hs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_first_of_file,
    input  logic       s_last_of_file,
    output logic       item_valid,
    output item_t      item,
    input  logic       item_take
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // register is free when empty or when its beat moves on this cycle
    assign s_ready    = !valid_reg || item_take;
    assign valid_next = s_valid || (valid_reg && !item_take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= '{data_byte: s_data_byte,
                          first_of_file: s_first_of_file,
                          last_of_file: s_last_of_file};
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

### rtl/crc32hs_engine.sv
module crc32hs_engine
    import crc32hs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        item_valid,
    input  item_t       item,
    output logic        item_take,
    input  logic        cfg_valid,
    input  logic [7:0]  cfg_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_crc_value
);

    logic [7:0]  skip_reg;
    logic [31:0] crc_reg;
    logic [31:0] crc_next;
    logic [7:0]  left_reg;
    logic [7:0]  left_next;
    logic        m_valid_reg;
    logic [31:0] result_reg;

    logic [31:0] crc_start;
    logic [7:0]  left_start;
    logic [31:0] crc_upd;
    logic        fire;
    logic        out_free;

    // header skip count, taken at each restart
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skip_reg <= HEADER_SKIP_RESET;
        end else if (cfg_valid) begin
            skip_reg <= cfg_data;
        end
    end

    // a last beat needs room in the result register
    assign out_free  = !m_valid_reg || m_ready;
    assign item_take = !item.last_of_file || out_free;
    assign fire      = item_valid && item_take;

    // restart on first mark, then skip or hash the byte
    always_comb begin
        crc_start  = item.first_of_file ? CRC_ALL_ONES : crc_reg;
        left_start = item.first_of_file ? skip_reg : left_reg;
        crc_upd    = crc_start;
        left_next  = left_start;
        if (left_start != 8'd0) begin
            left_next = left_start - 8'd1;
        end else begin
            crc_upd = crc_update_byte(crc_start, item.data_byte);
        end
        crc_next = crc_upd;
        // rearm after the last byte
        if (item.last_of_file) begin
            crc_next  = CRC_ALL_ONES;
            left_next = skip_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg  <= CRC_ALL_ONES;
            left_reg <= 8'd0;
        end else if (fire) begin
            crc_reg  <= crc_next;
            left_reg <= left_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire && item.last_of_file) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && item.last_of_file) begin
            result_reg <= ~crc_upd;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_crc_value = result_reg;

    // checks
    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.last_of_file |=> m_valid_reg)
        else $error("last beat did not load the result register");

    a_rearm_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.last_of_file |=> crc_reg == CRC_ALL_ONES)
        else $error("crc not rearmed after last beat");

    a_header_count_down: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && !item.last_of_file && left_start != 8'd0
        |=> left_reg == $past(left_start) - 8'd1 && crc_reg == $past(crc_start))
        else $error("header byte not skipped correctly");

    a_state_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !fire |=> $stable(crc_reg) && $stable(left_reg))
        else $error("crc state moved without a beat");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |-> !(fire && item.last_of_file))
        else $error("result overwritten before being taken");

endmodule

### rtl/crc32_after_header_skip.sv
// CRC-32 (reflected, polynomial 0xEDB88320, start all ones, final inversion)
// over each file of a byte stream, after discarding the first header_skip
// bytes of the file (16 after reset). One byte is taken every clock cycle,
// save while a last-marked beat waits: a beat sits in the input register, then
// a single byte-wide CRC update moves it into the running state, and on a
// last-marked beat m_valid rises the cycle after the update. A result waiting
// on m_ready holds back only the next last-marked beat; other bytes keep
// flowing. A file no longer than its header gives 0. After a last byte the
// block rearms, so a following byte without a first mark starts a new file.
// header_skip is written through cfg_valid/cfg_data and takes effect at the
// next file start.
module crc32_after_header_skip
    import crc32hs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_first_of_file,
    input  logic        s_last_of_file,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_crc_value,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    logic  item_valid;
    item_t item;
    logic  item_take;

    // register writes always land at once
    assign cfg_ready = 1'b1;

    crc32hs_in_reg u_in_reg (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_first_of_file (s_first_of_file),
        .s_last_of_file  (s_last_of_file),
        .item_valid      (item_valid),
        .item            (item),
        .item_take       (item_take)
    );

    crc32hs_engine u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_valid  (item_valid),
        .item        (item),
        .item_take   (item_take),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_crc_value (m_crc_value)
    );

endmodule
